/* hdl/bvg_pkg.sv */
// bvg_pkg: shared types, constants and the charge table of the battery voltage gauge
// used by every module under hdl/
package bvg_pkg;

  localparam int ADC_BITS = 12;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 18;
  localparam int SCALE_W  = 18;
  localparam int OFFS_W   = 11;
  localparam int ALPHA_W  = 17;
  localparam int LIMIT_W  = 7;
  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int FILT_W   = 29;
  localparam int MUL_A_W  = 29;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int QUO_W    = SUM_W + SCALE_W;
  localparam int REM_W    = 6;
  localparam int DIV_W    = REM_W + SCALE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int TABLE_LEN  = 12;

  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [ALPHA_W-1:0]  Q16_ONE  = ALPHA_W'(65536);
  localparam logic [FILT_W-1:0]   V_MAX    = FILT_W'(64'd8191 << 16);
  localparam logic [PCT_W-1:0]    PCT_FLOOR = PCT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_SCALE    = 2'd0,
    REG_OFFSET       = 2'd1,
    REG_FILTER_ALPHA = 2'd2,
    REG_JUMP_LIMIT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SUM,
    ST_SPLIT,
    ST_MUL_REM,
    ST_DIV_REM,
    ST_OFFSET,
    ST_MUL_F,
    ST_MUL_V,
    ST_BLEND,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MSEL_QUO_SCALE,
    MSEL_REM_SCALE,
    MSEL_F_KEEP,
    MSEL_V_ALPHA
  } mul_sel_t;

  typedef enum logic {
    DSEL_SUM,
    DSEL_PROD
  } div_sel_t;

  typedef struct packed {
    logic     in_stall;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_en;
    div_sel_t div_sel;
  } ctrl_t;

  typedef logic [MV_W-1:0]  mv_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam mv_t THR_MV [TABLE_LEN] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3950, 13'd3900, 13'd3850,
    13'd3800, 13'd3750, 13'd3700, 13'd3650, 13'd3600, 13'd3550
  };
  localparam pct_t THR_PCT [TABLE_LEN] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd70,
    7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
  };

  // first threshold from the top that the voltage reaches wins
  function automatic pct_t lookup_percent(input mv_t mv);
    pct_t p;
    p = PCT_FLOOR;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (mv >= THR_MV[i]) p = THR_PCT[i];
    end
    return p;
  endfunction

endpackage

/* hdl/bvg_mul.sv */
// bvg_mul: shared unsigned multiplier with registered product
// depends on bvg_pkg for operand widths
module bvg_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bvg_pkg::MUL_A_W-1:0]  a,
  input  logic [bvg_pkg::MUL_B_W-1:0]  b,
  output logic [bvg_pkg::PROD_W-1:0]   p
);

  logic [bvg_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) prod_r <= bvg_pkg::PROD_W'(a) * bvg_pkg::PROD_W'(b);
  end

  assign p = prod_r;

endmodule

/* hdl/bvg_div.sv */
// bvg_div: division by the constant group size through a reciprocal multiply
// depends on bvg_pkg for the dividend width
module bvg_div #(
  parameter int SAMPLES = 10
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bvg_pkg::DIV_W-1:0]  dividend,
  output logic [bvg_pkg::DIV_W-1:0]  quotient
);

  localparam int DW = bvg_pkg::DIV_W;
  localparam int SH = DW + $clog2(SAMPLES);
  localparam int RW = SH + 1;
  localparam int PW = DW + RW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

  logic [PW-1:0] prod;
  logic [DW-1:0] quo_r;

  // rounded-up reciprocal gives the exact floor for every dividend below 2**DW
  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) quo_r <= prod[SH +: DW];
  end

  assign quotient = quo_r;

endmodule

/* hdl/battery_voltage_gauge.sv */
// battery_voltage_gauge: top level, sequencer and datapath registers of the gauge
// depends on bvg_pkg, bvg_mul and bvg_div
//
// Samples are summed one per cycle; every SAMPLES-th sample ends a group and the
// block then stalls its input while one shared multiplier and a reciprocal divider
// by the group size work out the group voltage, the low-pass filter and the charge
// percent. The group sum is split into quotient and remainder by the group size so
// that each scaled part stays narrow. A sample that ends a group runs the sequencer
// through its divide, split, multiply, divide, offset, filter and emit steps (the
// very first group skips the filter steps and loads the filter directly), plus any
// wait for the previous result to be taken. A result waiting in the output register
// does not block new samples until the next group end.
module battery_voltage_gauge #(
  parameter int SAMPLES = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bvg_pkg::SAMPLE_W-1:0]    in_adc_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bvg_pkg::MV_W-1:0]        out_voltage_mv,
  output logic [bvg_pkg::PCT_W-1:0]       out_percent,
  input  logic                            cfg_we,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int VS_W  = bvg_pkg::QUO_W + 2;

  bvg_pkg::state_t state_r, state_nxt;
  bvg_pkg::ctrl_t  ctrl;

  logic [bvg_pkg::SCALE_W-1:0]  scale_r;
  logic [bvg_pkg::OFFS_W-1:0]   offset_r;
  logic [bvg_pkg::ALPHA_W-1:0]  alpha_r;
  logic [bvg_pkg::LIMIT_W-1:0]  limit_r;

  logic [CNT_W-1:0]             group_count_r;
  logic [bvg_pkg::SUM_W-1:0]    sample_sum_r;
  logic [bvg_pkg::REM_W-1:0]    rem_r;
  logic [bvg_pkg::FILT_W-1:0]   filt_r;
  logic [bvg_pkg::FILT_W-1:0]   v_r;
  logic [bvg_pkg::PROD_W-1:0]   acc_r;
  logic                         primed_r;
  logic [bvg_pkg::PCT_W-1:0]    prev_pct_r;
  logic                         pct_known_r;
  logic                         out_valid_r;
  logic [bvg_pkg::MV_W-1:0]     out_mv_r;
  logic [bvg_pkg::PCT_W-1:0]    out_pct_r;

  logic                         in_fire, out_fire, group_end, emit_go;
  logic [CNT_W-1:0]             count_inc;
  logic [bvg_pkg::SUM_W-1:0]    sum_inc;
  logic [bvg_pkg::ALPHA_W-1:0]  alpha_c, keep_c;
  logic [bvg_pkg::MUL_A_W-1:0]  mul_a;
  logic [bvg_pkg::MUL_B_W-1:0]  mul_b;
  logic [bvg_pkg::PROD_W-1:0]   mul_p;
  logic [bvg_pkg::PROD_W-1:0]   blend_sum;
  logic [bvg_pkg::DIV_W-1:0]    div_in;
  logic [bvg_pkg::DIV_W-1:0]    div_quo;
  logic [bvg_pkg::REM_W-1:0]    rem_c;
  logic [bvg_pkg::QUO_W-1:0]    v_quo;
  logic signed [VS_W-1:0]       v_s;
  logic [bvg_pkg::FILT_W-1:0]   v_sat;
  logic [bvg_pkg::MV_W-1:0]     mv;
  logic [bvg_pkg::PCT_W-1:0]    pct_raw, pct_diff, pct_sel;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign count_inc = group_count_r + CNT_W'(1);
  assign group_end = (count_inc >= CNT_W'(SAMPLES));
  assign sum_inc   = sample_sum_r + bvg_pkg::SUM_W'(in_adc_sample & bvg_pkg::ADC_MASK);
  assign emit_go   = !out_valid_r || !out_stall;

  assign alpha_c = (alpha_r > bvg_pkg::Q16_ONE) ? bvg_pkg::Q16_ONE : alpha_r;
  assign keep_c  = bvg_pkg::Q16_ONE - alpha_c;

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bvg_pkg::ST_IDLE:     if (in_fire && group_end) state_nxt = bvg_pkg::ST_DIV_SUM;
      bvg_pkg::ST_DIV_SUM:  state_nxt = bvg_pkg::ST_SPLIT;
      bvg_pkg::ST_SPLIT:    state_nxt = bvg_pkg::ST_MUL_REM;
      bvg_pkg::ST_MUL_REM:  state_nxt = bvg_pkg::ST_DIV_REM;
      bvg_pkg::ST_DIV_REM:  state_nxt = bvg_pkg::ST_OFFSET;
      bvg_pkg::ST_OFFSET:   state_nxt = primed_r ? bvg_pkg::ST_MUL_F : bvg_pkg::ST_EMIT;
      bvg_pkg::ST_MUL_F:    state_nxt = bvg_pkg::ST_MUL_V;
      bvg_pkg::ST_MUL_V:    state_nxt = bvg_pkg::ST_BLEND;
      bvg_pkg::ST_BLEND:    state_nxt = bvg_pkg::ST_EMIT;
      bvg_pkg::ST_EMIT:     if (emit_go) state_nxt = bvg_pkg::ST_IDLE;
      default:              state_nxt = bvg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{in_stall: 1'b1, mul_en: 1'b0, mul_sel: bvg_pkg::MSEL_QUO_SCALE,
             div_en: 1'b0, div_sel: bvg_pkg::DSEL_SUM};
    case (state_r)
      bvg_pkg::ST_IDLE:    ctrl.in_stall = 1'b0;
      bvg_pkg::ST_DIV_SUM: begin
        ctrl.div_en  = 1'b1;
        ctrl.div_sel = bvg_pkg::DSEL_SUM;
      end
      bvg_pkg::ST_SPLIT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bvg_pkg::MSEL_QUO_SCALE;
      end
      bvg_pkg::ST_MUL_REM: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bvg_pkg::MSEL_REM_SCALE;
      end
      bvg_pkg::ST_DIV_REM: begin
        ctrl.div_en  = 1'b1;
        ctrl.div_sel = bvg_pkg::DSEL_PROD;
      end
      bvg_pkg::ST_MUL_F: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bvg_pkg::MSEL_F_KEEP;
      end
      bvg_pkg::ST_MUL_V: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = bvg_pkg::MSEL_V_ALPHA;
      end
      default: ;
    endcase
  end

  assign in_stall = ctrl.in_stall;

  // ---- shared multiplier ----
  always_comb begin
    case (ctrl.mul_sel)
      bvg_pkg::MSEL_QUO_SCALE: begin
        mul_a = bvg_pkg::MUL_A_W'(div_quo);
        mul_b = scale_r;
      end
      bvg_pkg::MSEL_REM_SCALE: begin
        mul_a = bvg_pkg::MUL_A_W'(rem_r);
        mul_b = scale_r;
      end
      bvg_pkg::MSEL_F_KEEP: begin
        mul_a = filt_r;
        mul_b = bvg_pkg::MUL_B_W'(keep_c);
      end
      bvg_pkg::MSEL_V_ALPHA: begin
        mul_a = v_r;
        mul_b = bvg_pkg::MUL_B_W'(alpha_c);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bvg_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sum first, then the remainder times the scale
  assign div_in = (ctrl.div_sel == bvg_pkg::DSEL_SUM) ? bvg_pkg::DIV_W'(sample_sum_r)
                                                      : mul_p[bvg_pkg::DIV_W-1:0];

  bvg_div #(.SAMPLES(SAMPLES)) u_div (
    .clk      (clk),
    .en       (ctrl.div_en),
    .dividend (div_in),
    .quotient (div_quo)
  );

  // remainder is below the group size, so the low bits of the difference are exact
  assign rem_c = sample_sum_r[bvg_pkg::REM_W-1:0]
               - bvg_pkg::REM_W'(div_quo[bvg_pkg::REM_W-1:0] * bvg_pkg::REM_W'(SAMPLES));

  // sum*scale/n = q*scale + floor(r*scale/n)
  assign v_quo = acc_r[bvg_pkg::QUO_W-1:0] + bvg_pkg::QUO_W'(div_quo);

  // offset in mV moves to Q16 then the reading saturates to the 13-bit range
  always_comb begin
    v_s = $signed({2'b00, v_quo})
        + $signed({{(VS_W - bvg_pkg::OFFS_W - 16){offset_r[bvg_pkg::OFFS_W-1]}},
                   offset_r, 16'h0000});
    if (v_s < 0) begin
      v_sat = '0;
    end else if (v_s > $signed(VS_W'(bvg_pkg::V_MAX))) begin
      v_sat = bvg_pkg::V_MAX;
    end else begin
      v_sat = v_s[bvg_pkg::FILT_W-1:0];
    end
  end

  assign blend_sum = acc_r + mul_p;

  // ---- percent and jump rejection ----
  assign mv       = filt_r[bvg_pkg::FILT_W-1:16];
  assign pct_raw  = bvg_pkg::lookup_percent(mv);
  assign pct_diff = (pct_raw > prev_pct_r) ? (pct_raw - prev_pct_r) : (prev_pct_r - pct_raw);
  assign pct_sel  = (pct_known_r && (pct_diff > limit_r)) ? prev_pct_r : pct_raw;

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bvg_pkg::ST_IDLE;
      scale_r       <= bvg_pkg::SCALE_W'(109851);
      offset_r      <= '0;
      alpha_r       <= bvg_pkg::ALPHA_W'(9830);
      limit_r       <= bvg_pkg::LIMIT_W'(5);
      group_count_r <= '0;
      sample_sum_r  <= '0;
      filt_r        <= '0;
      primed_r      <= 1'b0;
      prev_pct_r    <= '0;
      pct_known_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (bvg_pkg::cfg_reg_t'(cfg_index))
          bvg_pkg::REG_ADC_SCALE:    scale_r  <= cfg_wdata[bvg_pkg::SCALE_W-1:0];
          bvg_pkg::REG_OFFSET:       offset_r <= cfg_wdata[bvg_pkg::OFFS_W-1:0];
          bvg_pkg::REG_FILTER_ALPHA: alpha_r  <= cfg_wdata[bvg_pkg::ALPHA_W-1:0];
          bvg_pkg::REG_JUMP_LIMIT:   limit_r  <= cfg_wdata[bvg_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        group_count_r <= group_end ? '0 : count_inc;
      end

      // sum is last read when the remainder is taken
      if (in_fire) sample_sum_r <= sum_inc;
      else if (state_r == bvg_pkg::ST_SPLIT) sample_sum_r <= '0;

      if (state_r == bvg_pkg::ST_OFFSET && !primed_r) begin
        filt_r   <= v_sat;
        primed_r <= 1'b1;
      end
      if (state_r == bvg_pkg::ST_BLEND) filt_r <= blend_sum[bvg_pkg::FILT_W+15:16];

      if (state_r == bvg_pkg::ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
        prev_pct_r  <= pct_sel;
        pct_known_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end

    if (state_r == bvg_pkg::ST_SPLIT) rem_r <= rem_c;
    if (state_r == bvg_pkg::ST_OFFSET) v_r <= v_sat;
    if (state_r == bvg_pkg::ST_MUL_REM || state_r == bvg_pkg::ST_MUL_V) acc_r <= mul_p;
    if (state_r == bvg_pkg::ST_EMIT && emit_go) begin
      out_mv_r  <= mv;
      out_pct_r <= pct_sel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_voltage_mv = out_mv_r;
  assign out_percent    = out_pct_r;

  // ---- checks ----
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=>
      (out_valid_r && $stable(out_mv_r) && $stable(out_pct_r)))
    else $error("stalled result changed");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    group_count_r < CNT_W'(SAMPLES))
    else $error("group count reached the group size");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bvg_pkg::ST_IDLE && !in_fire) |=> (state_r == bvg_pkg::ST_IDLE))
    else $error("sequencer left idle without a request");

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= bvg_pkg::PCT_W'(100)))
    else $error("percent above 100");

  a_emit_primed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (primed_r && pct_known_r))
    else $error("result emitted before the filter was loaded");

endmodule
